FILE: hw/rtl/tms_pkg.sv
// Shared types and constants for the transform matrix stack.
// Request and response beat layouts, command and error codes, CORDIC arctangents.
// No dependencies.
package tms_pkg;

  typedef struct packed {
    logic [3:0]         req_type;
    logic               stack_sel;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic [63:0]        mat_pair_0;
    logic [63:0]        mat_pair_1;
    logic [63:0]        mat_pair_2;
    logic [63:0]        mat_pair_3;
    logic [63:0]        mat_pair_4;
    logic [63:0]        mat_pair_5;
    logic [63:0]        mat_pair_6;
    logic [63:0]        mat_pair_7;
  } req_t;

  typedef struct packed {
    logic [63:0] top_pair_0;
    logic [63:0] top_pair_1;
    logic [63:0] top_pair_2;
    logic [63:0] top_pair_3;
    logic [63:0] top_pair_4;
    logic [63:0] top_pair_5;
    logic [63:0] top_pair_6;
    logic [63:0] top_pair_7;
    logic [4:0]  stack_depth;
    logic [1:0]  error_code;
  } rsp_t;

  // command codes
  localparam logic [3:0] CMD_PUSH      = 4'd0;
  localparam logic [3:0] CMD_POP       = 4'd1;
  localparam logic [3:0] CMD_IDENT     = 4'd2;
  localparam logic [3:0] CMD_IDENT_BYP = 4'd3;
  localparam logic [3:0] CMD_LOAD      = 4'd4;
  localparam logic [3:0] CMD_LOAD_BYP  = 4'd5;
  localparam logic [3:0] CMD_CONCAT    = 4'd6;
  localparam logic [3:0] CMD_TRANSLATE = 4'd7;
  localparam logic [3:0] CMD_ROTATE    = 4'd8;
  localparam logic [3:0] CMD_USCALE    = 4'd9;
  localparam logic [3:0] CMD_SCALE     = 4'd10;
  localparam logic [3:0] CMD_CLEAR     = 4'd11;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_POP_LAST  = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

  localparam int unsigned       CORDIC_STEPS = 28;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i in Q30 binary angle units
  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/transform_matrix_stack.sv
// Transform matrix stack: view and model stacks of 4x4 Q matrices in one RAM.
// One command at a time: a new request is accepted only after the response beat of
// the last one has been taken, so a response stall also holds off the next command.
// The 16-word RAM read and write sweeps, the one-element-per-cycle product (four
// multipliers) and the 28-step CORDIC make up the time each command takes.
// Reset: synchronous; both depths return to one and level 0 of each stack reads
// identity until written. Depends on tms_pkg.
module transform_matrix_stack #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tms_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tms_pkg::rsp_t rsp
);
  import tms_pkg::*;

  localparam int LVL_W     = $clog2(STACK_DEPTH);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int AW        = 1 + LVL_W + 4;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int SH        = 30 - FRAC_BITS;
  localparam logic [31:0]        ONE     = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [65:0] MHALF   = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [34:0] CSHALF  = 35'sd1 <<< (SH - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0]   CNT_ONE = CNT_W'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_ANG1 = 4'd2;
  localparam logic [3:0] S_ANG2 = 4'd3;
  localparam logic [3:0] S_CORD = 4'd4;
  localparam logic [3:0] S_CS   = 4'd5;
  localparam logic [3:0] S_CSW  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_CPY  = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  function automatic logic [31:0] ident_word(input logic [3:0] e);
    return (e[1:0] == e[3:2]) ? ONE : 32'd0;
  endfunction

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Q30 to output fraction, round half up, saturate
  function automatic logic [31:0] q30fix(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = (v + CSHALF) >>> SH;
    return sat66(66'(t));
  endfunction

  // state
  logic [3:0]       state;
  logic [4:0]       seq;
  logic [CNT_W-1:0] cnt_v, cnt_m, cnt_new;
  logic [1:0]       lvl0_ok;
  logic [3:0]       cmd;
  logic             sel;
  logic [31:0]      a_arg, b_arg;
  logic [1:0]       err;
  logic             src_stk;
  logic [LVL_W-1:0] src_lvl, dst_lvl;
  logic [31:0]      mat_a [16];
  logic [31:0]      mat_t [16];
  logic [31:0]      mat_r [16];

  // RAM
  logic [31:0]      mem [MEM_DEPTH];
  logic [31:0]      rdata;
  logic             rd_id;

  // product pipe
  logic signed [63:0] prod [4];
  logic [3:0]         pe;
  logic               pv;

  // CORDIC
  logic signed [62:0] ang_p;
  logic signed [64:0] ang_q;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [1:0]         quad;
  logic [31:0]        c_r, s_r;

  // request decode
  logic [CNT_W-1:0] cur_cnt;
  logic             is_full, is_last;
  logic [63:0]      pairs [8];
  logic [31:0]      op_w [16];

  assign cur_cnt = req.stack_sel ? cnt_m : cnt_v;
  assign is_full = cur_cnt >= CNT_MAX;
  assign is_last = cur_cnt <= CNT_ONE;

  always_comb begin
    pairs[0] = req.mat_pair_0;
    pairs[1] = req.mat_pair_1;
    pairs[2] = req.mat_pair_2;
    pairs[3] = req.mat_pair_3;
    pairs[4] = req.mat_pair_4;
    pairs[5] = req.mat_pair_5;
    pairs[6] = req.mat_pair_6;
    pairs[7] = req.mat_pair_7;
    for (int e = 0; e < 16; e++) begin
      op_w[e] = e[0] ? pairs[e >> 1][63:32] : pairs[e >> 1][31:0];
    end
  end

  assign req_stall = (state != S_IDLE);

  // counter value after the command
  always_comb begin
    cnt_new = sel ? cnt_m : cnt_v;
    if (cmd == CMD_PUSH && err == ERR_OK) cnt_new = cnt_new + CNT_ONE;
    else if (cmd == CMD_POP && err == ERR_OK) cnt_new = cnt_new - CNT_ONE;
    else if (cmd == CMD_CLEAR) cnt_new = CNT_ONE;
  end

  // RAM ports: one read, one write
  always_ff @(posedge clk) begin
    rdata <= mem[{src_stk, src_lvl, seq[3:0]}];
    rd_id <= (src_lvl == '0) && !lvl0_ok[src_stk];
    if (state == S_WR) begin
      mem[{sel, dst_lvl, seq[3:0]}] <= mat_t[seq[3:0]];
    end
  end

  // product pipe: four products per cycle, then sum, round and saturate
  always_ff @(posedge clk) begin
    logic signed [65:0] acc;
    acc = MHALF;
    for (int k = 0; k < 4; k++) begin
      acc = acc + 66'(prod[k]);
    end
    if (state == S_MUL && !seq[4]) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= $signed(mat_a[{seq[3:2], 2'(k)}]) * $signed(mat_t[{2'(k), seq[1:0]}]);
      end
    end
    pe <= seq[3:0];
    if (pv) begin
      mat_r[pe] <= sat66(acc >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == S_MUL) && !seq[4];
    end
  end

  // sequencer and data registers
  always_ff @(posedge clk) begin
    logic signed [63:0] bsum;
    logic [31:0]        bang;
    logic [1:0]         qd;
    logic signed [33:0] xs, ys;
    logic signed [34:0] cc, ss;
    logic signed [32:0] ns;
    bsum = 64'(ang_p) + 64'(ang_q >>> 32);
    bang = 32'(bsum >>> FRAC_BITS);
    qd   = 2'((bang + 32'h2000_0000) >> 30);
    xs   = cx >>> seq;
    ys   = cy >>> seq;
    case (quad)
      2'd0:    begin cc = 35'(cx);  ss = 35'(cy);  end
      2'd1:    begin cc = -35'(cy); ss = 35'(cx);  end
      2'd2:    begin cc = -35'(cx); ss = -35'(cy); end
      default: begin cc = 35'(cy);  ss = -35'(cx); end
    endcase
    ns = -33'($signed(s_r));

    if (rst) begin
      state   <= S_IDLE;
      seq     <= '0;
      cnt_v   <= CNT_ONE;
      cnt_m   <= CNT_ONE;
      lvl0_ok <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          seq <= '0;
          if (req_valid) begin
            cmd   <= req.req_type;
            sel   <= req.stack_sel;
            a_arg <= req.arg_a;
            b_arg <= req.arg_b;
            err   <= ERR_OK;
            if (req.req_type == CMD_PUSH && is_full) err <= ERR_PUSH_FULL;
            if (req.req_type == CMD_POP && is_last) err <= ERR_POP_LAST;
            // source level to read
            if ((req.req_type == CMD_IDENT || req.req_type == CMD_LOAD) && req.stack_sel) begin
              src_stk <= 1'b0;
              src_lvl <= LVL_W'(cnt_v - CNT_ONE);
            end else begin
              src_stk <= req.stack_sel;
              if (req.req_type == CMD_POP && !is_last)
                src_lvl <= LVL_W'(cur_cnt - CNT_W'(2));
              else
                src_lvl <= LVL_W'(cur_cnt - CNT_ONE);
            end
            // destination level to write
            if (req.req_type == CMD_PUSH) dst_lvl <= LVL_W'(cur_cnt);
            else if (req.req_type == CMD_CLEAR) dst_lvl <= '0;
            else dst_lvl <= LVL_W'(cur_cnt - CNT_ONE);
            // left operand
            for (int e = 0; e < 16; e++) begin
              mat_a[e] <= ident_word(4'(e));
            end
            case (req.req_type)
              CMD_LOAD, CMD_LOAD_BYP, CMD_CONCAT: begin
                for (int e = 0; e < 16; e++) mat_a[e] <= op_w[e];
              end
              CMD_TRANSLATE: begin
                mat_a[3] <= req.arg_a;
                mat_a[7] <= req.arg_b;
              end
              CMD_USCALE: begin
                mat_a[0]  <= req.arg_a;
                mat_a[5]  <= req.arg_a;
                mat_a[10] <= req.arg_a;
              end
              CMD_SCALE: begin
                mat_a[0] <= req.arg_a;
                mat_a[5] <= req.arg_b;
              end
              default: ;
            endcase
            state <= S_RD;
          end
        end

        // read the source matrix, one word a cycle
        S_RD: begin
          if (seq != '0) begin
            mat_t[4'(seq - 5'd1)] <= rd_id ? ident_word(4'(seq - 5'd1)) : rdata;
          end
          seq <= seq + 5'd1;
          if (seq == 5'd16) begin
            seq <= '0;
            case (cmd)
              CMD_PUSH:  state <= (err == ERR_OK) ? S_WR : S_FIN;
              CMD_IDENT: begin
                if (!sel) for (int e = 0; e < 16; e++) mat_t[e] <= ident_word(4'(e));
                state <= S_WR;
              end
              CMD_IDENT_BYP, CMD_CLEAR: begin
                for (int e = 0; e < 16; e++) mat_t[e] <= ident_word(4'(e));
                state <= S_WR;
              end
              CMD_LOAD: begin
                if (sel) state <= S_MUL;
                else begin
                  for (int e = 0; e < 16; e++) mat_t[e] <= mat_a[e];
                  state <= S_WR;
                end
              end
              CMD_LOAD_BYP: begin
                for (int e = 0; e < 16; e++) mat_t[e] <= mat_a[e];
                state <= S_WR;
              end
              CMD_CONCAT, CMD_TRANSLATE, CMD_USCALE, CMD_SCALE: state <= S_MUL;
              CMD_ROTATE: state <= S_ANG1;
              default: state <= S_FIN;
            endcase
          end
        end

        // angle to binary angle
        S_ANG1: begin
          ang_p <= 63'($signed(a_arg)) * 63'sd683565275;
          ang_q <= 65'($signed(a_arg)) * 65'sd2475754826;
          state <= S_ANG2;
        end

        S_ANG2: begin
          quad  <= qd;
          cz    <= 33'($signed(bang - {qd, 30'd0}));
          cx    <= CORDIC_GAIN;
          cy    <= '0;
          seq   <= '0;
          state <= S_CORD;
        end

        // one CORDIC rotation a cycle
        S_CORD: begin
          if (!cz[32]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - 33'(atan_step(seq));
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + 33'(atan_step(seq));
          end
          seq <= seq + 5'd1;
          if (seq == 5'(CORDIC_STEPS - 1)) begin
            seq   <= '0;
            state <= S_CS;
          end
        end

        S_CS: begin
          c_r   <= q30fix(cc);
          s_r   <= q30fix(ss);
          state <= S_CSW;
        end

        S_CSW: begin
          mat_a[0] <= c_r;
          mat_a[1] <= sat66(66'(ns));
          mat_a[4] <= s_r;
          mat_a[5] <= c_r;
          state    <= S_MUL;
        end

        // one result element a cycle, plus pipe drain
        S_MUL: begin
          seq <= seq + 5'd1;
          if (seq == 5'd16) begin
            seq   <= '0;
            state <= S_CPY;
          end
        end

        S_CPY: begin
          for (int e = 0; e < 16; e++) mat_t[e] <= mat_r[e];
          state <= S_WR;
        end

        // write back the top, one word a cycle
        S_WR: begin
          if (dst_lvl == '0) lvl0_ok[sel] <= 1'b1;
          seq <= seq + 5'd1;
          if (seq == 5'd15) begin
            seq   <= '0;
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (sel) cnt_m <= cnt_new;
          else cnt_v <= cnt_new;
          rsp.top_pair_0  <= {mat_t[1], mat_t[0]};
          rsp.top_pair_1  <= {mat_t[3], mat_t[2]};
          rsp.top_pair_2  <= {mat_t[5], mat_t[4]};
          rsp.top_pair_3  <= {mat_t[7], mat_t[6]};
          rsp.top_pair_4  <= {mat_t[9], mat_t[8]};
          rsp.top_pair_5  <= {mat_t[11], mat_t[10]};
          rsp.top_pair_6  <= {mat_t[13], mat_t[12]};
          rsp.top_pair_7  <= {mat_t[15], mat_t[14]};
          rsp.stack_depth <= 5'(cnt_new);
          rsp.error_code  <= err;
          rsp_valid <= 1'b1;
          state     <= S_OUT;
        end

        S_OUT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_rsp_only_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> state == S_OUT) else $error("response beat outside output state");
  a_view_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt_v >= CNT_ONE && cnt_v <= CNT_MAX) else $error("view depth out of range");
  a_model_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt_m >= CNT_ONE && cnt_m <= CNT_MAX) else $error("model depth out of range");
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN) else $error("response without finish");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    pv |-> $past(state) == S_MUL) else $error("product pipe active outside multiply");

endmodule

FILE: sim/tms_checker.sv
// Checker for the transform matrix stack: watches both channels, keeps its own
// copy of both matrix stacks, predicts every response beat and compares it.
// Depends on tms_pkg.
`timescale 1ns / 1ps

module tms_checker #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  tms_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  tms_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            rsp_count,
  output int            full_hits,
  output int            last_hits
);
  import tms_pkg::*;

  typedef logic [15:0][31:0] mat_t;

  // arctangent of 2^-i, Q30 binary angle
  localparam logic signed [31:0] ATAN_Q30 [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  mat_t   levels [2][STACK_DEPTH];
  int     depth [2];
  rsp_t   expected_tops [$];

  function automatic logic [31:0] clamp32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'h7fff_ffff;
    if (v < -68'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic mat_t unity();
    mat_t m;
    m = '0;
    for (int e = 0; e < 16; e += 5) m[e] = 32'(1) << FRAC_BITS;
    return m;
  endfunction

  // a * b, exact sum, round half up at the fraction shift, then clamp
  function automatic mat_t mat_product(input mat_t a, input mat_t b);
    mat_t r;
    logic signed [67:0] acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc = acc + $signed(a[i*4+k]) * $signed(b[k*4+j]);
        acc = (acc + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r[i*4+j] = clamp32(acc);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] q30_round(input logic signed [63:0] v);
    logic signed [67:0] w;
    w = v;
    w = (w + (68'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    return clamp32(w);
  endfunction

  // rotation about z: binary angle, quadrant fold, 28 CORDIC steps
  function automatic mat_t z_rotation(input logic signed [31:0] t);
    mat_t m;
    logic signed [63:0] p, q, ang, x, y, z, xs, ys, c, s;
    logic [31:0] bang;
    logic [1:0] quad;
    logic signed [31:0] zr;
    logic [31:0] cw, sw;
    p = t;
    q = t;
    p = p * 64'sd683565275;
    q = q * 64'sd2475754826;
    ang = (p + (q >>> 32)) >>> FRAC_BITS;
    bang = ang[31:0];
    quad = 2'((bang + 32'h2000_0000) >> 30);
    zr = bang - {quad, 30'd0};
    z = zr;
    x = 64'sd652032874;
    y = '0;
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_Q30[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_Q30[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cw = q30_round(c);
    sw = q30_round(s);
    m = unity();
    m[0] = cw;
    m[1] = clamp32(-$signed({{36{sw[31]}}, sw}));
    m[4] = sw;
    m[5] = cw;
    return m;
  endfunction

  // apply one command to the shadow stacks and form its response
  task automatic apply_command(input req_t r, output rsp_t o);
    mat_t op, t;
    logic sel;
    logic [1:0] err;
    sel = r.stack_sel;
    err = ERR_OK;
    op = {r.mat_pair_7, r.mat_pair_6, r.mat_pair_5, r.mat_pair_4,
          r.mat_pair_3, r.mat_pair_2, r.mat_pair_1, r.mat_pair_0};
    case (r.req_type)
      CMD_PUSH: begin
        if (depth[sel] >= STACK_DEPTH) err = ERR_PUSH_FULL;
        else begin
          levels[sel][depth[sel]] = levels[sel][depth[sel]-1];
          depth[sel]++;
        end
      end
      CMD_POP: begin
        if (depth[sel] <= 1) err = ERR_POP_LAST;
        else depth[sel]--;
      end
      CMD_IDENT:
        levels[sel][depth[sel]-1] = sel ? levels[0][depth[0]-1] : unity();
      CMD_IDENT_BYP:
        levels[sel][depth[sel]-1] = unity();
      CMD_LOAD:
        levels[sel][depth[sel]-1] = sel ? mat_product(op, levels[0][depth[0]-1]) : op;
      CMD_LOAD_BYP:
        levels[sel][depth[sel]-1] = op;
      CMD_CONCAT, CMD_TRANSLATE, CMD_ROTATE, CMD_USCALE, CMD_SCALE: begin
        if (r.req_type == CMD_TRANSLATE) begin
          op = unity(); op[3] = r.arg_a; op[7] = r.arg_b;
        end else if (r.req_type == CMD_ROTATE) begin
          op = z_rotation(r.arg_a);
        end else if (r.req_type == CMD_USCALE) begin
          op = unity(); op[0] = r.arg_a; op[5] = r.arg_a; op[10] = r.arg_a;
        end else if (r.req_type == CMD_SCALE) begin
          op = unity(); op[0] = r.arg_a; op[5] = r.arg_b;
        end
        levels[sel][depth[sel]-1] = mat_product(op, levels[sel][depth[sel]-1]);
      end
      CMD_CLEAR: begin
        depth[sel] = 1;
        levels[sel][0] = unity();
      end
      default: ;
    endcase
    t = levels[sel][depth[sel]-1];
    o.top_pair_0 = {t[1], t[0]};
    o.top_pair_1 = {t[3], t[2]};
    o.top_pair_2 = {t[5], t[4]};
    o.top_pair_3 = {t[7], t[6]};
    o.top_pair_4 = {t[9], t[8]};
    o.top_pair_5 = {t[11], t[10]};
    o.top_pair_6 = {t[13], t[12]};
    o.top_pair_7 = {t[15], t[14]};
    o.stack_depth = 5'(depth[sel]);
    o.error_code = err;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    rsp_t want, pred;
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        depth[s] = 1;
        levels[s][0] = unity();
      end
      expected_tops.delete();
      fail_count = 0;
      rsp_count = 0;
      full_hits = 0;
      last_hits = 0;
    end else begin
      if (req_valid && !req_stall) begin
        apply_command(req, pred);
        if (pred.error_code == ERR_PUSH_FULL) full_hits++;
        if (pred.error_code == ERR_POP_LAST) last_hits++;
        expected_tops.push_back(pred);
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_count++;
        if (expected_tops.size() == 0) begin
          $error("response beat with no command outstanding");
          fail_count++;
        end else begin
          want = expected_tops.pop_front();
          check_field("top_pair_0", want.top_pair_0, rsp.top_pair_0);
          check_field("top_pair_1", want.top_pair_1, rsp.top_pair_1);
          check_field("top_pair_2", want.top_pair_2, rsp.top_pair_2);
          check_field("top_pair_3", want.top_pair_3, rsp.top_pair_3);
          check_field("top_pair_4", want.top_pair_4, rsp.top_pair_4);
          check_field("top_pair_5", want.top_pair_5, rsp.top_pair_5);
          check_field("top_pair_6", want.top_pair_6, rsp.top_pair_6);
          check_field("top_pair_7", want.top_pair_7, rsp.top_pair_7);
          check_field("stack_depth", 64'(want.stack_depth), 64'(rsp.stack_depth));
          check_field("error_code", 64'(want.error_code), 64'(rsp.error_code));
        end
      end
    end
    pending = expected_tops.size();
  end

endmodule

FILE: sim/transform_matrix_stack_tb.sv
// Testbench top for transform_matrix_stack: clock, reset, command stimulus,
// response stall, watchdog and verdict. Depends on tms_pkg and tms_checker.
`timescale 1ns / 1ps

module transform_matrix_stack_tb;
  import tms_pkg::*;

  localparam int ITEMS    = 750;
  localparam int WD_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count, pending, rsp_count, full_hits, last_hits;
  int sent = 0;
  int rsp_wait = 0;
  int wd_count = 0;
  bit idle_on = 1'b1;
  bit drained = 1'b0;

  always #4 clk = ~clk;

  transform_matrix_stack i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  tms_checker i_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .rsp_count(rsp_count),
    .full_hits(full_hits), .last_hits(last_hits)
  );

  // response side: stall each beat for a wait drawn when the beat before it was taken; no wait while idle_on is clear
  always @(negedge clk) begin
    if (rsp_valid && rsp_wait > 0) begin
      rsp_stall <= 1'b1;
      rsp_wait <= rsp_wait - 1;
    end else begin
      rsp_stall <= 1'b0;
      if (rsp_valid) rsp_wait <= idle_on ? $urandom_range(0, 6) : 0;
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      wd_count <= 0;
    end else if (wd_count >= WD_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'h0001_0000 + $urandom_range(0, 32767) - 16384;
      3: return 32'hffff_0000 - $urandom_range(0, 16384);
      default: return $urandom_range(0, 262143) - 131072;
    endcase
  endfunction

  function automatic req_t make_cmd(input logic [3:0] cmd, input logic sel,
                                    input logic [31:0] a, input logic [31:0] b);
    req_t r;
    logic [15:0][31:0] m;
    bit full;
    full = ($urandom_range(0, 7) == 0);
    for (int e = 0; e < 16; e++)
      m[e] = full ? $urandom() : ((e % 5 == 0) ? rand_word()
                                   : 32'($urandom_range(0, 131071)) - 32'd65536);
    r.req_type = cmd;
    r.stack_sel = sel;
    r.arg_a = a;
    r.arg_b = b;
    {r.mat_pair_7, r.mat_pair_6, r.mat_pair_5, r.mat_pair_4,
     r.mat_pair_3, r.mat_pair_2, r.mat_pair_1, r.mat_pair_0} = m;
    return r;
  endfunction

  // one request beat: optional gap, then hold until accepted
  task automatic send(input req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [3:0] cmd;
    cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                       : 4'($urandom_range(0, 11));
    send(make_cmd(cmd, 1'($urandom_range(0, 1)), rand_word(), rand_word()));
  endtask

  initial begin
    logic sel;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every command, extreme arguments, last-level pop errors
    send(make_cmd(CMD_POP, 1'b0, 0, 0));
    send(make_cmd(CMD_POP, 1'b1, 0, 0));
    send(make_cmd(CMD_TRANSLATE, 1'b0, 32'h0003_0000, 32'hfffe_0000));
    send(make_cmd(CMD_PUSH, 1'b0, 0, 0));
    send(make_cmd(CMD_ROTATE, 1'b0, 32'd102944, 0));
    send(make_cmd(CMD_IDENT, 1'b1, 0, 0));
    send(make_cmd(CMD_LOAD, 1'b1, 0, 0));
    send(make_cmd(CMD_LOAD_BYP, 1'b1, 0, 0));
    send(make_cmd(CMD_IDENT_BYP, 1'b1, 0, 0));
    send(make_cmd(CMD_ROTATE, 1'b1, 32'h8000_0000, 0));
    send(make_cmd(CMD_ROTATE, 1'b1, 32'h7fff_ffff, 0));
    send(make_cmd(CMD_ROTATE, 1'b1, 32'd0, 0));
    send(make_cmd(CMD_ROTATE, 1'b1, 32'd205887, 0));
    send(make_cmd(CMD_USCALE, 1'b1, 32'h7fff_ffff, 0));
    send(make_cmd(CMD_USCALE, 1'b1, 32'h8000_0000, 0));
    send(make_cmd(CMD_SCALE, 1'b1, 32'h0002_0000, 32'hffff_8000));
    send(make_cmd(CMD_TRANSLATE, 1'b1, 32'h7fff_ffff, 32'h8000_0000));
    send(make_cmd(CMD_CONCAT, 1'b1, 0, 0));
    send(make_cmd(CMD_LOAD, 1'b0, 0, 0));
    send(make_cmd(CMD_IDENT, 1'b0, 0, 0));
    send(make_cmd(4'd12, 1'b0, 0, 0));
    send(make_cmd(4'd15, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
    send(make_cmd(CMD_CLEAR, 1'b0, 0, 0));
    send(make_cmd(CMD_CLEAR, 1'b1, 0, 0));

    // random: mostly single commands, with fill and drain runs to hit the ends
    while (sent < ITEMS) begin
      if (sent % 150 < 20) idle_on = 1'b0;
      else idle_on = 1'b1;
      if (!drained && sent > ITEMS / 2) begin
        // let the pipe drain completely before resuming
        drained = 1'b1;
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      case ($urandom_range(0, 19))
        0: begin
          sel = 1'($urandom_range(0, 1));
          repeat (17) send(make_cmd(CMD_PUSH, sel, rand_word(), rand_word()));
        end
        1: begin
          sel = 1'($urandom_range(0, 1));
          repeat (17) send(make_cmd(CMD_POP, sel, rand_word(), rand_word()));
        end
        default: send_random();
      endcase
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d commands, checked %0d responses (%0d full-stack pushes, %0d last-level pops).",
             sent, rsp_count, full_hits, last_hits);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tms_pkg.sv
hw/rtl/transform_matrix_stack.sv
sim/tms_checker.sv
sim/transform_matrix_stack_tb.sv
